/* rtl/core/pcc_pkg.sv */
// Package for the posture change classifier.
// Posture codes, command and register indexes, widths, shared types and helpers.
// No dependencies.
package pcc_pkg;

  localparam int unsigned CoordW  = 12;
  localparam int unsigned CentreW = 13;
  localparam int unsigned ThrW    = 12;
  localparam int unsigned CountW  = 8;
  localparam int unsigned RegIdxW = 2;

  typedef enum logic [2:0] {
    POST_UNKNOWN      = 3'd0,
    POST_STANDING_UP  = 3'd1,
    POST_SITTING_DOWN = 3'd2,
    POST_SIT          = 3'd3,
    POST_STAND        = 3'd4
  } posture_e;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_FRAME = 1'b1;

  localparam logic [RegIdxW-1:0] REG_INIT_THR  = 2'd0;
  localparam logic [RegIdxW-1:0] REG_MOVE_THR  = 2'd1;
  localparam logic [RegIdxW-1:0] REG_NEAR_THR  = 2'd2;
  localparam logic [RegIdxW-1:0] REG_CHECK_INT = 2'd3;

  localparam logic [ThrW-1:0]   INIT_THR_RST  = 12'd80;
  localparam logic [ThrW-1:0]   MOVE_THR_RST  = 12'd30;
  localparam logic [ThrW-1:0]   NEAR_THR_RST  = 12'd50;
  localparam logic [CountW-1:0] CHECK_INT_RST = 8'd10;

  typedef struct packed {
    logic [ThrW-1:0]   init_thr;
    logic [ThrW-1:0]   move_thr;
    logic [ThrW-1:0]   near_thr;
    logic [CountW-1:0] check_int;
  } cfg_t;

  typedef struct packed {
    logic               command;
    logic               box_found;
    logic [CentreW-1:0] centre;
  } item_t;

  typedef struct packed {
    posture_e           posture;
    posture_e           initial_posture;
    logic               posture_known;
    logic [CentreW-1:0] centre_y;
  } result_t;

  function automatic logic [CentreW-1:0] abs_diff(input logic [CentreW-1:0] a,
                                                  input logic [CentreW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

/* rtl/core/pcc_intake.sv */
// Input register of the posture change classifier: takes one word, forms the box centre.
// Depends on pcc_pkg.
module pcc_intake (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic                drain_i,
  input  logic                command_i,
  input  logic                box_found_i,
  input  logic [pcc_pkg::CoordW-1:0] box_top_i,
  input  logic [pcc_pkg::CoordW-1:0] box_height_i,
  output logic                valid_o,
  output pcc_pkg::item_t      item_o
);

  logic           valid_q, valid_d;
  pcc_pkg::item_t item_q;

  always_comb begin
    valid_d = valid_q;
    if (drain_i) valid_d = 1'b0;
    if (load_i)  valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q.command   <= command_i;
      item_q.box_found <= box_found_i;
      item_q.centre    <= {1'b0, box_top_i} + {2'b00, box_height_i[pcc_pkg::CoordW-1:1]};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* rtl/core/pcc_track.sv */
// Tracking state and posture classification for one person.
// Updates the centres, the postures and the frame counter per item. Depends on pcc_pkg.
module pcc_track (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  pcc_pkg::item_t   item_i,
  input  pcc_pkg::cfg_t    cfg_i,
  output pcc_pkg::result_t result_o
);

  logic [pcc_pkg::CentreW-1:0] origin_q, origin_d;
  logic [pcc_pkg::CentreW-1:0] cur_q, cur_d;
  logic [pcc_pkg::CentreW-1:0] prev_q, prev_d;
  logic [pcc_pkg::CentreW-1:0] ext_q, ext_d;
  pcc_pkg::posture_e           init_q, init_d;
  pcc_pkg::posture_e           post_q, post_d;
  logic [pcc_pkg::CountW-1:0]  cnt_q, cnt_d;
  logic [pcc_pkg::CountW-1:0]  cnt_inc;

  always_comb begin
    origin_d = origin_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    ext_d    = ext_q;
    init_d   = init_q;
    post_d   = post_q;
    cnt_d    = cnt_q;
    cnt_inc  = cnt_q + 8'd1;
    if (item_i.command == pcc_pkg::CMD_START) begin
      origin_d = item_i.centre;
      cur_d    = item_i.centre;
      prev_d   = item_i.centre;
      ext_d    = item_i.centre;
      init_d   = pcc_pkg::POST_UNKNOWN;
      post_d   = pcc_pkg::POST_UNKNOWN;
      cnt_d    = '0;
    end else begin
      if (item_i.box_found) begin
        cur_d = item_i.centre;
        if (cur_d > origin_q && cur_d > ext_q) ext_d = cur_d;
        if (cur_d < origin_q && cur_d < ext_q) ext_d = cur_d;
      end
      if (init_q == pcc_pkg::POST_UNKNOWN &&
          pcc_pkg::abs_diff(cur_d, origin_q) > {1'b0, cfg_i.init_thr}) begin
        init_d = (cur_d > origin_q) ? pcc_pkg::POST_STAND : pcc_pkg::POST_SIT;
      end
      cnt_d = cnt_inc;
      if (cnt_inc == cfg_i.check_int) begin
        cnt_d  = '0;
        prev_d = cur_d;
        if (pcc_pkg::abs_diff(prev_q, cur_d) > {1'b0, cfg_i.move_thr}) begin
          post_d = (cur_d > prev_q) ? pcc_pkg::POST_SITTING_DOWN
                                    : pcc_pkg::POST_STANDING_UP;
        end else if (pcc_pkg::abs_diff(cur_d, origin_q) < {1'b0, cfg_i.near_thr}) begin
          post_d = init_d;
        end else if (pcc_pkg::abs_diff(cur_d, ext_d) < {1'b0, cfg_i.near_thr}) begin
          post_d = (init_d == pcc_pkg::POST_SIT) ? pcc_pkg::POST_STAND : pcc_pkg::POST_SIT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
      cur_q    <= '0;
      prev_q   <= '0;
      ext_q    <= '0;
      init_q   <= pcc_pkg::POST_UNKNOWN;
      post_q   <= pcc_pkg::POST_UNKNOWN;
      cnt_q    <= '0;
    end else if (step_i) begin
      origin_q <= origin_d;
      cur_q    <= cur_d;
      prev_q   <= prev_d;
      ext_q    <= ext_d;
      init_q   <= init_d;
      post_q   <= post_d;
      cnt_q    <= cnt_d;
    end
  end

  assign result_o.posture         = post_d;
  assign result_o.initial_posture = init_d;
  assign result_o.posture_known   = (init_d != pcc_pkg::POST_UNKNOWN);
  assign result_o.centre_y        = cur_d;

endmodule

/* rtl/core/posture_change_classifier.sv */
// Top level of the posture change classifier: stream ports, config registers, result register.
// Instantiates pcc_intake and pcc_track. Depends on pcc_pkg.
//
// One word in, one word out. A word is taken every cycle while the result register is free
// or being drained; its result passes through the input register and then, behind one level
// of compare logic, the result register before it reaches the master side. Start words (tuser
// bit 0 low) reset the tracking; frame words update it. Config writes are always ready and
// take effect at once; write them only while no word is in flight.
module posture_change_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // box_top[11:0], box_height[23:12]
  input  logic [1:0]  s_axis_tuser,   // command[0], box_found[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // posture[2:0], initial_posture[5:3],
                                      // posture_known[6], centre_y[19:7], zero[23:20]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [pcc_pkg::RegIdxW-1:0] cfg_index_i,
  input  logic [pcc_pkg::ThrW-1:0]    cfg_data_i
);

  pcc_pkg::cfg_t    cfg_q;
  pcc_pkg::item_t   item;
  pcc_pkg::result_t result;
  pcc_pkg::result_t out_q;
  logic             in_valid;
  logic             out_valid_q;
  logic             advance;

  assign advance       = in_valid && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_thr  <= pcc_pkg::INIT_THR_RST;
      cfg_q.move_thr  <= pcc_pkg::MOVE_THR_RST;
      cfg_q.near_thr  <= pcc_pkg::NEAR_THR_RST;
      cfg_q.check_int <= pcc_pkg::CHECK_INT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pcc_pkg::REG_INIT_THR:  cfg_q.init_thr  <= cfg_data_i;
        pcc_pkg::REG_MOVE_THR:  cfg_q.move_thr  <= cfg_data_i;
        pcc_pkg::REG_NEAR_THR:  cfg_q.near_thr  <= cfg_data_i;
        pcc_pkg::REG_CHECK_INT: cfg_q.check_int <= cfg_data_i[pcc_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  pcc_intake u_intake (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (s_axis_tvalid && s_axis_tready),
    .drain_i      (advance),
    .command_i    (s_axis_tuser[0]),
    .box_found_i  (s_axis_tuser[1]),
    .box_top_i    (s_axis_tdata[11:0]),
    .box_height_i (s_axis_tdata[23:12]),
    .valid_o      (in_valid),
    .item_o       (item)
  );

  pcc_track u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= result;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q.centre_y, out_q.posture_known,
                          out_q.initial_posture, out_q.posture};

endmodule

/* tb/tb.sv */
// Self-checking testbench for posture_change_classifier: stream stimulus, config phases,
// and a scoreboard class that predicts every result word. Depends on pcc_pkg and the RTL top.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 4000;
  localparam int HoldCycles    = 400;
  localparam int HoldAfter     = 500;

  class posture_scoreboard;
    logic [pcc_pkg::ThrW-1:0]    init_thr;
    logic [pcc_pkg::ThrW-1:0]    move_thr;
    logic [pcc_pkg::ThrW-1:0]    near_thr;
    logic [pcc_pkg::CountW-1:0]  check_int;
    logic [pcc_pkg::CentreW-1:0] origin_y;
    logic [pcc_pkg::CentreW-1:0] current_y;
    logic [pcc_pkg::CentreW-1:0] previous_y;
    logic [pcc_pkg::CentreW-1:0] extreme_y;
    pcc_pkg::posture_e           initial_p;
    pcc_pkg::posture_e           posture_p;
    logic [pcc_pkg::CountW-1:0]  frame_cnt;
    pcc_pkg::result_t            expected_q[$];
    int                          mismatches;
    int                          checked;
    int                          checks_fired;

    function new();
      init_thr     = pcc_pkg::INIT_THR_RST;
      move_thr     = pcc_pkg::MOVE_THR_RST;
      near_thr     = pcc_pkg::NEAR_THR_RST;
      check_int    = pcc_pkg::CHECK_INT_RST;
      origin_y     = '0;
      current_y    = '0;
      previous_y   = '0;
      extreme_y    = '0;
      initial_p    = pcc_pkg::POST_UNKNOWN;
      posture_p    = pcc_pkg::POST_UNKNOWN;
      frame_cnt    = '0;
      mismatches   = 0;
      checked      = 0;
      checks_fired = 0;
    endfunction

    function int gap(input int a, input int b);
      return (a > b) ? a - b : b - a;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(input logic [pcc_pkg::RegIdxW-1:0] idx,
                            input logic [pcc_pkg::ThrW-1:0] val);
      case (idx)
        pcc_pkg::REG_INIT_THR:  init_thr  = val;
        pcc_pkg::REG_MOVE_THR:  move_thr  = val;
        pcc_pkg::REG_NEAR_THR:  near_thr  = val;
        pcc_pkg::REG_CHECK_INT: check_int = val[pcc_pkg::CountW-1:0];
        default: ;
      endcase
    endfunction

    function void note_word(input logic cmd, input logic found,
                            input logic [pcc_pkg::CoordW-1:0] top,
                            input logic [pcc_pkg::CoordW-1:0] height);
      logic [pcc_pkg::CentreW-1:0] centre;
      int cur, prv, org, mv, nr;
      pcc_pkg::result_t r;
      centre = {1'b0, top} + {2'b00, height[pcc_pkg::CoordW-1:1]};
      if (cmd == pcc_pkg::CMD_START) begin
        origin_y   = centre;
        current_y  = centre;
        previous_y = centre;
        extreme_y  = centre;
        initial_p  = pcc_pkg::POST_UNKNOWN;
        posture_p  = pcc_pkg::POST_UNKNOWN;
        frame_cnt  = '0;
      end else begin
        if (found) begin
          current_y = centre;
          if (current_y > origin_y && current_y > extreme_y) extreme_y = current_y;
          if (current_y < origin_y && current_y < extreme_y) extreme_y = current_y;
        end
        cur = int'(current_y);
        org = int'(origin_y);
        if (initial_p == pcc_pkg::POST_UNKNOWN && gap(cur, org) > int'(init_thr)) begin
          initial_p = (cur > org) ? pcc_pkg::POST_STAND : pcc_pkg::POST_SIT;
        end
        frame_cnt = frame_cnt + 8'd1;
        if (frame_cnt == check_int) begin
          prv = int'(previous_y);
          mv  = int'(move_thr);
          nr  = int'(near_thr);
          frame_cnt = '0;
          checks_fired++;
          if (gap(prv, cur) > mv) begin
            if (cur - prv > mv) posture_p = pcc_pkg::POST_SITTING_DOWN;
            if (prv - cur > mv) posture_p = pcc_pkg::POST_STANDING_UP;
          end else if (gap(cur, org) < nr) begin
            posture_p = initial_p;
          end else if (gap(cur, int'(extreme_y)) < nr) begin
            posture_p = (initial_p == pcc_pkg::POST_SIT) ? pcc_pkg::POST_STAND
                                                          : pcc_pkg::POST_SIT;
          end
          previous_y = current_y;
        end
      end
      r.posture         = posture_p;
      r.initial_posture = initial_p;
      r.posture_known   = (initial_p != pcc_pkg::POST_UNKNOWN);
      r.centre_y        = current_y;
      expected_q = {expected_q, r};
    endfunction

    function void check_word(input logic [23:0] tdata);
      pcc_pkg::result_t exp_r;
      logic [2:0] act_post, act_init;
      logic act_known;
      logic [pcc_pkg::CentreW-1:0] act_centre;
      act_post   = tdata[2:0];
      act_init   = tdata[5:3];
      act_known  = tdata[6];
      act_centre = tdata[19:7];
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result word %h", tdata);
        return;
      end
      exp_r = expected_q.pop_front();
      if (act_post !== exp_r.posture || act_init !== exp_r.initial_posture ||
          act_known !== exp_r.posture_known || act_centre !== exp_r.centre_y) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d exp post=%0d init=%0d known=%0d y=%0d",
                   checked, exp_r.posture, exp_r.initial_posture, exp_r.posture_known,
                   exp_r.centre_y);
          $display("       got post=%0d init=%0d known=%0d y=%0d",
                   act_post, act_init, act_known, act_centre);
        end
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [23:0]                  s_axis_tdata;
  logic [1:0]                   s_axis_tuser;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [23:0]                  m_axis_tdata;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [pcc_pkg::RegIdxW-1:0]  cfg_index_i;
  logic [pcc_pkg::ThrW-1:0]     cfg_data_i;

  posture_scoreboard sb = new();
  int  words_sent;
  int  cfg_writes;
  int  settings_run;
  bit  sender_quiet;

  posture_change_classifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    if (sender_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input logic cmd, input logic found,
                           input logic [pcc_pkg::CoordW-1:0] top,
                           input logic [pcc_pkg::CoordW-1:0] height);
    int idle;
    idle = pick_gap();
    if (idle > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {found, cmd};
    s_axis_tdata  <= {height, top};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(cmd, found, top, height);
    words_sent++;
  endtask

  task automatic write_reg(input logic [pcc_pkg::RegIdxW-1:0] idx,
                           input logic [pcc_pkg::ThrW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_writes++;
  endtask

  // all words drained, then spare idle cycles for the pipeline
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [pcc_pkg::ThrW-1:0] init_v,
                               input logic [pcc_pkg::ThrW-1:0] move_v,
                               input logic [pcc_pkg::ThrW-1:0] near_v,
                               input logic [pcc_pkg::ThrW-1:0] chk_v);
    wait_drained();
    write_reg(pcc_pkg::REG_INIT_THR, init_v);
    write_reg(pcc_pkg::REG_MOVE_THR, move_v);
    write_reg(pcc_pkg::REG_NEAR_THR, near_v);
    write_reg(pcc_pkg::REG_CHECK_INT, chk_v);
    cfg_valid_i <= 1'b0;
    settings_run++;
  endtask

  // tracked runs: a start word (usually), then frames drifting with a per-run bias; also random single words
  task automatic run_phase(input int budget);
    int done, len, per, top, span, bias, step;
    logic [pcc_pkg::CoordW-1:0] height;
    logic found;
    done = 0;
    while (done < budget) begin
      sender_quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 12) begin
        send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        done++;
      end else begin
        per = (sb.check_int == 0) ? 256 : int'(sb.check_int);
        len = (per > 60) ? $urandom_range(per - 8, per + 30) : $urandom_range(4, 3 * per + 6);
        height = 12'($urandom_range(0, 4095));
        top = $urandom_range(0, 4095);
        case ($urandom_range(0, 3))
          0: span = 4;
          1: span = 25;
          2: span = 80;
          default: span = 400;
        endcase
        bias = (int'($urandom_range(0, 2)) - 1) * span / 3;
        if ($urandom_range(0, 99) < 88) begin
          send_word(pcc_pkg::CMD_START, 1'($urandom_range(0, 1)), 12'(top), height);
          done++;
        end
        if (len > budget - done) len = budget - done;
        repeat (len) begin
          step = $urandom_range(0, 2 * span);
          top = top + step - span + bias;
          if (top < 0) top = 0;
          if (top > 4095) top = 4095;
          found = ($urandom_range(0, 99) < 92);
          if (found) send_word(pcc_pkg::CMD_FRAME, 1'b1, 12'(top), height);
          else send_word(pcc_pkg::CMD_FRAME, 1'b0, 12'($urandom_range(0, 4095)),
                         12'($urandom_range(0, 4095)));
          done++;
        end
      end
    end
  endtask

  // receiver: random stalls, quiet stretches, one long hold-off
  initial begin
    int stall_left, seen, cyc;
    bit held;
    stall_left = 0;
    seen = 0;
    cyc = 0;
    held = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_word(m_axis_tdata);
        seen++;
      end
      if (!held && seen >= HoldAfter) begin
        held = 1'b1;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (cyc[8] && $urandom_range(0, 99) < 30) begin
          stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(1, 3);
        end
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    words_sent = 0;
    cfg_writes = 0;
    settings_run = 1;
    sender_quiet = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset config: ignored found on start, lost box, stand fix, sit-down check
    send_word(pcc_pkg::CMD_START, 1'b0, 12'd1000, 12'd200);
    send_word(pcc_pkg::CMD_FRAME, 1'b1, 12'd1000, 12'd200);
    send_word(pcc_pkg::CMD_FRAME, 1'b0, 12'd4095, 12'd4095);
    repeat (7) send_word(pcc_pkg::CMD_FRAME, 1'b1, 12'd1100, 12'd201);
    send_word(pcc_pkg::CMD_FRAME, 1'b1, 12'd1100, 12'd200);
    // field extremes
    send_word(pcc_pkg::CMD_START, 1'b1, 12'd0, 12'd0);
    send_word(pcc_pkg::CMD_FRAME, 1'b1, 12'd4095, 12'd4095);
    send_word(pcc_pkg::CMD_FRAME, 1'b1, 12'd0, 12'd1);
    send_word(pcc_pkg::CMD_FRAME, 1'b0, 12'd0, 12'd0);
    // upward move fixes sit, then lingers near the extreme with no move
    send_word(pcc_pkg::CMD_START, 1'b0, 12'd4095, 12'd0);
    send_word(pcc_pkg::CMD_FRAME, 1'b1, 12'd0, 12'd4094);
    repeat (9) send_word(pcc_pkg::CMD_FRAME, 1'b1, 12'd2000, 12'd94);
    send_word(pcc_pkg::CMD_FRAME, 1'b0, 12'd0, 12'd0);

    run_phase(200);
    apply_setting(12'd0, 12'd0, 12'd0, 12'd1);
    run_phase(200);
    apply_setting(12'd4095, 12'd4095, 12'd4095, 12'd4095);
    run_phase(300);
    apply_setting(12'($urandom_range(20, 150)), 12'($urandom_range(5, 60)),
                  12'($urandom_range(10, 100)), 12'($urandom_range(2, 20)));
    run_phase(300);
    apply_setting(12'd0, 12'd0, 12'd0, 12'd0);
    run_phase(300);
    apply_setting(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                  12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
    run_phase(200);
    apply_setting(12'($urandom_range(20, 150)), 12'($urandom_range(5, 60)),
                  12'($urandom_range(10, 100)), 12'($urandom_range(2, 20)));
    run_phase(250);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) sb.mismatches++;
    $display("Run: %0d input words over %0d config settings (%0d register writes)",
             words_sent, settings_run, cfg_writes);
    $display("     %0d result words checked, %0d periodic posture checks, %0d mismatches",
             sb.checked, sb.checks_fired, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
